// File: rtl/stat_pkg.sv
// Shared types and constants for the segment table address translator.
`timescale 1ns / 1ps
package stat_pkg;
    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_BOOT     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_STORED   = 3'd3;
    localparam logic [2:0] ST_DISCARD  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic [2:0] CLS_PFI         = 3'd0;
    localparam logic [2:0] CLS_ECPRI       = 3'd1;
    localparam logic [2:0] CLS_PFI_LOCAL   = 3'd2;
    localparam logic [2:0] CLS_ECPRI_LOCAL = 3'd3;
    localparam logic [2:0] CLS_GLOBAL      = 3'd4;

    localparam logic [31:0] DSP_BASE0   = 32'h1A00_0000;
    localparam logic [31:0] DSP_STRIDE  = 32'h0080_0000;
    localparam logic [31:0] DSP_DISC    = 32'h0020_0000;
    localparam logic [31:0] PFI_OR      = 32'h0300_0000;
    localparam logic [31:0] ECPRI_OR    = 32'h0700_0000;
    localparam logic [15:0] LOCAL_TAG   = 16'h7000;
    localparam logic [31:0] LOCAL_LIMIT = 32'h0000_2000;
    localparam logic [31:0] BOOT_BASE   = 32'h0308_0000;

    // Job kinds handed from front to back
    typedef enum logic [2:0] {
        J_STORE, J_RESULT, J_DSP, J_CODE, J_LOCAL, J_GLOBAL
    } t_job;

    typedef struct packed {
        t_job        kind;
        logic [2:0]  cls;
        logic [2:0]  status;
        logic [31:0] addr;
        logic [31:0] foff;
        logic [31:0] size;
        logic [15:0] range;
        logic [5:0]  core;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_GSCAN, S_WAIT, S_OUT
    } t_state;
endpackage

// File: rtl/segment_table_address_translator_top.sv
// Top level of the segment table address translator.
`timescale 1ns / 1ps
// Channel  | Dir | Content
// s_axis   | in  | tdata: opcode, seg_address, seg_type, seg_file_offset, seg_size,
//          |     |        query_address, query_core
// m_axis   | out | tdata: status, image_offset
// cfg      | in  | boot_stage_done
// Loads and boot/DSP translates need no table search. Table searches read one
// entry per cycle from the segment memory, in up to two passes.
// Reset is synchronous; the table needs no clearing pass (fill count).
// A one-deep command register between front and back lets each side stall.
module segment_table_address_translator_top import stat_pkg::*; #(
    parameter int SEGMENTS = 32,
    parameter int DSP_CORES = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // opcode[0], seg_address[32:1], seg_type[64:33], seg_file_offset[96:65],
    // seg_size[128:97], query_address[160:129], query_core[166:161]
    input  logic [167:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // status[2:0], image_offset[34:3]
    output logic [39:0]   m_axis_tdata,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);
    logic r_boot;
    logic q_valid, q_ready;
    t_cmd q_cmd;
    logic [2:0] st;
    logic [31:0] ofs;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_boot <= 1'b0;
        else if (i_cfg_valid) r_boot <= i_cfg_data;
    end

    stat_front #(.DSP_CORES(DSP_CORES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_boot_done(r_boot),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_opcode(s_axis_tdata[0]), .i_seg_address(s_axis_tdata[32:1]),
        .i_seg_type(s_axis_tdata[64:33]), .i_seg_file_offset(s_axis_tdata[96:65]),
        .i_seg_size(s_axis_tdata[128:97]), .i_query_address(s_axis_tdata[160:129]),
        .i_query_core(s_axis_tdata[166:161]),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    stat_back #(.SEGMENTS(SEGMENTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_cmd(q_cmd), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(st), .o_offset(ofs)
    );

    assign m_axis_tdata = {5'd0, ofs, st};
endmodule

// File: rtl/stat_front.sv
// Front end: classifies loads and translates, resolves DSP and boot cases.
`timescale 1ns / 1ps
module stat_front import stat_pkg::*; #(
    parameter int DSP_CORES = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_boot_done,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_opcode,
    input  logic [31:0]  i_seg_address,
    input  logic [31:0]  i_seg_type,
    input  logic [31:0]  i_seg_file_offset,
    input  logic [31:0]  i_seg_size,
    input  logic [31:0]  i_query_address,
    input  logic [5:0]   i_query_core,
    output logic         o_valid,
    input  logic         i_ready,
    output t_cmd         o_cmd
);
    logic         r_valid;
    t_cmd         r_cmd, n_cmd;
    logic [31:0]  r_dsp [DSP_CORES];
    logic [DSP_CORES-1:0] r_dsp_v;
    logic         dsp_hit;
    logic [$clog2(DSP_CORES+1)-1:0] dsp_idx;
    logic         acc;
    logic [7:0]   first, last;
    logic [31:0]  top;
    logic [5:0]   dcore;

    assign o_ready = !r_valid || i_ready;
    assign acc = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_cmd = r_cmd;
    assign top = i_seg_address & 32'hFF00_0000;
    assign first = i_seg_type[7:0];
    assign last = i_seg_type[15:8];
    assign dcore = i_query_core - 6'd32;

    // DSP address match, first index wins
    always_comb begin
        dsp_hit = 1'b0;
        dsp_idx = '0;
        for (int i = DSP_CORES - 1; i >= 0; i--) begin
            if (i_seg_address == DSP_BASE0 + DSP_STRIDE * i) begin
                dsp_hit = 1'b1;
                dsp_idx = ($clog2(DSP_CORES+1))'(i);
            end
        end
    end

    // Classification
    always_comb begin
        logic disc;
        disc = 1'b0;
        for (int i = 0; i < DSP_CORES; i++)
            if (i_seg_address == DSP_BASE0 + DSP_STRIDE * i + DSP_DISC) disc = 1'b1;
        n_cmd = '0;
        n_cmd.kind = J_RESULT;
        n_cmd.addr = i_seg_address;
        n_cmd.foff = i_seg_file_offset;
        n_cmd.size = i_seg_size;
        n_cmd.core = i_query_core;
        if (!i_opcode) begin
            n_cmd.kind = J_STORE;
            if (dsp_hit) begin
                n_cmd.kind = J_RESULT;
                n_cmd.status = ST_STORED;
            end else if (disc) begin
                n_cmd.kind = J_RESULT;
                n_cmd.status = ST_DISCARD;
            end else if (top == 32'h0200_0000) begin
                n_cmd.addr = i_seg_address | PFI_OR;
                n_cmd.cls = CLS_PFI;
            end else if (top == 32'h0300_0000) begin
                n_cmd.cls = CLS_PFI;
            end else if (top == 32'h0500_0000) begin
                n_cmd.addr = i_seg_address | ECPRI_OR;
                n_cmd.cls = CLS_ECPRI;
            end else if (i_seg_type[31:16] == LOCAL_TAG) begin
                n_cmd.range = i_seg_type[15:0];
                if (first < 8'd16 && last < 8'd16) n_cmd.cls = CLS_PFI_LOCAL;
                else if (first >= 8'd16 && last >= 8'd16) n_cmd.cls = CLS_ECPRI_LOCAL;
                else begin
                    n_cmd.kind = J_RESULT;
                    n_cmd.status = ST_DISCARD;
                end
            end else begin
                n_cmd.cls = CLS_GLOBAL;
            end
        end else begin
            n_cmd.addr = i_query_address;
            if (!i_boot_done) begin
                n_cmd.status = ST_BOOT;
                n_cmd.foff = i_query_address - BOOT_BASE;
            end else if (i_query_core >= 6'd32) begin
                n_cmd.status = ST_NOTFOUND;
                for (int i = 0; i < DSP_CORES; i++) begin
                    if (dcore == 6'(i) && r_dsp_v[i]) begin
                        n_cmd.status = ST_HIT;
                        n_cmd.foff = r_dsp[i] + i_query_address;
                    end
                end
            end else if (i_query_address[31:25] == 7'd1) begin
                n_cmd.kind = J_CODE;
                n_cmd.cls = i_query_core < 6'd16 ? CLS_PFI : CLS_ECPRI;
                n_cmd.addr = i_query_address | (i_query_core < 6'd16 ? PFI_OR : ECPRI_OR);
            end else if (i_query_address < LOCAL_LIMIT) begin
                n_cmd.kind = J_LOCAL;
                n_cmd.cls = i_query_core < 6'd16 ? CLS_PFI_LOCAL : CLS_ECPRI_LOCAL;
            end else begin
                n_cmd.kind = J_GLOBAL;
                n_cmd.cls = CLS_GLOBAL;
            end
        end
        // offset is zero for every finished result other than a hit or boot
        if (n_cmd.kind == J_RESULT && n_cmd.status != ST_HIT && n_cmd.status != ST_BOOT)
            n_cmd.foff = '0;
    end

    // Command register and DSP base table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dsp_v <= '0;
        end else begin
            if (o_ready) r_valid <= i_valid;
            if (acc && !i_opcode && dsp_hit) r_dsp_v[dsp_idx] <= 1'b1;
        end
        if (acc) r_cmd <= n_cmd;
        if (acc && !i_opcode && dsp_hit) r_dsp[dsp_idx] <= i_seg_file_offset;
    end
endmodule

// File: rtl/stat_back.sv
// Back end: segment table memory and sequential search.
`timescale 1ns / 1ps
module stat_back import stat_pkg::*; #(
    parameter int SEGMENTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_offset
);
    localparam int CW = $clog2(SEGMENTS + 1);
    localparam int AW = $clog2(SEGMENTS);

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [CW-1:0] r_count, r_k;
    logic [2:0]  r_status;
    logic [31:0] r_offset;
    logic [31:0] m_base [SEGMENTS];
    logic [31:0] m_len  [SEGMENTS];
    logic [31:0] m_foff [SEGMENTS];
    logic [2:0]  m_cls  [SEGMENTS];
    logic [15:0] m_rng  [SEGMENTS];
    logic [31:0] rd_base, rd_len, rd_foff;
    logic [2:0]  rd_cls;
    logic [15:0] rd_rng;
    logic        r_rd_ok;
    logic        acc, hit, last_k;
    logic [31:0] off;
    logic [CW-1:0] rd_idx;

    assign o_ready = (r_state == S_IDLE);
    assign acc = i_valid && o_ready;
    assign off = r_cmd.addr - rd_base;
    // code search checks entry r_k walking down; others check entry r_k-1 walking up
    assign last_k = (r_cmd.kind == J_CODE) ? (r_k == '0) : (r_k >= r_count);

    // Read address: code search walks down, others walk up
    always_comb begin
        if (r_cmd.kind == J_CODE && (r_state == S_SCAN || r_state == S_WAIT))
            rd_idx = r_k - CW'(1);
        else rd_idx = r_k;
    end

    always_comb begin
        hit = 1'b0;
        if (r_rd_ok && rd_cls == r_cmd.cls) begin
            if (r_cmd.kind == J_LOCAL)
                hit = ({2'b0, r_cmd.core} >= rd_rng[7:0]) &&
                      ({2'b0, r_cmd.core} <= rd_rng[15:8]) && off < rd_len;
            else
                hit = rd_base <= r_cmd.addr && off < rd_len;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                if (i_cmd.kind == J_STORE || i_cmd.kind == J_RESULT) n_state = S_OUT;
                else if (i_cmd.kind == J_GLOBAL || r_count == '0) n_state = S_GSCAN;
                else n_state = S_SCAN;
            end
            S_SCAN, S_GSCAN: n_state = S_WAIT;
            S_WAIT: begin
                if (hit) n_state = S_OUT;
                else if (last_k && r_state == S_WAIT && r_cmd.cls == CLS_GLOBAL)
                    n_state = S_OUT;
                else if (last_k) n_state = S_GSCAN;
                else n_state = S_WAIT;
            end
            S_OUT: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_offset = r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (acc && i_cmd.kind == J_STORE && r_count != CW'(SEGMENTS))
                r_count <= r_count + CW'(1);
        end
        // memory read, registered
        r_rd_ok <= (rd_idx < r_count) &&
                   (r_state == S_SCAN || r_state == S_GSCAN || r_state == S_WAIT);
        if (rd_idx < r_count) begin
            rd_base <= m_base[rd_idx[AW-1:0]];
            rd_len  <= m_len[rd_idx[AW-1:0]];
            rd_foff <= m_foff[rd_idx[AW-1:0]];
            rd_cls  <= m_cls[rd_idx[AW-1:0]];
            rd_rng  <= m_rng[rd_idx[AW-1:0]];
        end
        if (acc) begin
            r_cmd <= i_cmd;
            r_k <= (i_cmd.kind == J_CODE) ? r_count : '0;
            if (i_cmd.kind == J_STORE) begin
                r_offset <= '0;
                if (r_count == CW'(SEGMENTS)) r_status <= ST_FULL;
                else begin
                    r_status <= ST_STORED;
                    m_base[r_count[AW-1:0]] <= i_cmd.addr;
                    m_len[r_count[AW-1:0]]  <= i_cmd.size;
                    m_foff[r_count[AW-1:0]] <= i_cmd.foff;
                    m_cls[r_count[AW-1:0]]  <= i_cmd.cls;
                    m_rng[r_count[AW-1:0]]  <= i_cmd.range;
                end
            end else begin
                r_status <= i_cmd.status;
                r_offset <= i_cmd.foff;
            end
        end
        // one entry per cycle: issue read in SCAN, evaluate in WAIT
        unique case (r_state)
            S_SCAN: begin
                if (r_cmd.kind == J_CODE) r_k <= r_k - CW'(1);
                else r_k <= r_k + CW'(1);
            end
            S_GSCAN: begin
                r_cmd.cls <= CLS_GLOBAL;
                r_cmd.kind <= J_GLOBAL;
                r_k <= CW'(1);
            end
            S_WAIT: begin
                if (hit) begin
                    r_status <= ST_HIT;
                    r_offset <= rd_foff + off;
                end else if (last_k) begin
                    if (r_cmd.cls == CLS_GLOBAL) begin
                        r_status <= ST_NOTFOUND;
                        r_offset <= '0;
                    end else begin
                        r_k <= '0;
                    end
                end else if (r_cmd.kind == J_CODE) r_k <= r_k - CW'(1);
                else r_k <= r_k + CW'(1);
            end
            default: ;
        endcase
    end
endmodule

// File: rtl/stat_checker.sv
// Port-level checks for the translator, bound to the top level.
`timescale 1ns / 1ps
module stat_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [39:0]  m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd5)
        else $error("bad status");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] >= 3'd2 |-> m_axis_tdata[34:3] == 32'd0)
        else $error("nonzero offset without hit");
endmodule

bind segment_table_address_translator_top stat_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
